>>> sv/byterun1_bitplane_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder assertion macros
// Checks on a clock edge, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BYTERUN1_BITPLANE_DECODER_UNIT_ASSERT_SVH
`define BYTERUN1_BITPLANE_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BR1BPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("br1bpd same-cycle check failed");

// next-cycle implication
`define BR1BPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("br1bpd next-cycle check failed");

`else

`define BR1BPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BR1BPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/br1bpd_pkg.sv
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder package
// Shared types, register indexes, codes and helper functions.
// ----------------------------------------------------------------------------
package br1bpd_pkg;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 14;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BYTES_PER_ROW = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_COUNT   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT     = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COMPRESSION   = 8'd3;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_EARLY_END = 2'd1;
    localparam logic [1:0] ERR_OVERRUN   = 2'd2;

    // control byte that does nothing
    localparam logic [7:0] CTRL_NOP = 8'h80;
    // longest run a single control byte can ask for
    localparam logic [7:0] RUN_MAX  = 8'd128;

    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } t_phase;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic cfg_wr;   // configuration word taken
        logic step;     // input word taken
        logic load;     // move next result word into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic has_result;  // current input word gives at least one result
        logic out_free;    // output register can take a word this cycle
        logic emit_last;   // word being emitted is the last of its byte
    } t_status;

    // zero row width acts as one
    function automatic logic [13:0] f_eff_bpr(input logic [13:0] v);
        f_eff_bpr = (v == 14'd0) ? 14'd1 : v;
    endfunction

    // zero row count acts as one
    function automatic logic [11:0] f_eff_rows(input logic [11:0] v);
        f_eff_rows = (v == 12'd0) ? 12'd1 : v;
    endfunction

endpackage

>>> sv/br1bpd_ctrl.sv
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder controller
// Takes one body byte at a time, then walks its result words out.
// ----------------------------------------------------------------------------
module br1bpd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_cfg_valid,
    input  br1bpd_pkg::t_status i_status,
    output logic                o_in_ready,
    output logic                o_cfg_ready,
    output br1bpd_pkg::t_cmd    o_cmd
);
    import br1bpd_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.step && i_status.has_result) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs; configuration wins over data in the same cycle
    always_comb begin
        o_cfg_ready = 1'b0;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_cfg_ready  = 1'b1;
                o_in_ready   = !i_cfg_valid;
                o_cmd.cfg_wr = i_cfg_valid;
                o_cmd.step   = i_in_valid && !i_cfg_valid;
            end
            S_EMIT: begin
                o_cmd.load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/br1bpd_datapath.sv
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder datapath
// Configuration, decode state, row/plane/image counters, result emitter
// and the output register.
// ----------------------------------------------------------------------------
module br1bpd_datapath #(
    parameter int MAX_PLANES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  br1bpd_pkg::t_cmd                    i_cmd,
    output br1bpd_pkg::t_status                 o_status,
    input  logic [br1bpd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [br1bpd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_end_of_body,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [15:0]                         o_byte_pair,
    output logic [1:0]                          o_pair_count,
    output logic [2:0]                          o_plane_index,
    output logic                                o_row_end,
    output logic                                o_image_end,
    output logic [1:0]                          o_error_code
);
    import br1bpd_pkg::*;

    localparam logic [3:0] PLANES_MAX = 4'(MAX_PLANES);

    // configuration
    logic [13:0] r_cfg_bpr,   n_cfg_bpr;
    logic [3:0]  r_cfg_planes, n_cfg_planes;
    logic [11:0] r_cfg_rows,  n_cfg_rows;
    logic        r_cfg_comp,  n_cfg_comp;

    // decode state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_lit,   n_lit;
    logic [7:0]  r_rep,   n_rep;
    logic [13:0] r_rbl,   n_rbl;
    logic [2:0]  r_plane, n_plane;
    logic [11:0] r_row,   n_row;
    logic        r_fin,   n_fin;

    // pending result words of the last byte
    logic [7:0]  r_em_byte;
    logic [7:0]  r_em_left, n_em_left;
    logic [2:0]  r_em_plane;
    logic        r_em_row_end;
    logic        r_em_img_end;
    logic [1:0]  r_em_err;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_pair;
    logic [1:0]  r_out_count;
    logic [2:0]  r_out_plane;
    logic        r_out_row_end;
    logic        r_out_img_end;
    logic [1:0]  r_out_err;

    // step results
    t_phase      s_phase;
    logic [7:0]  s_lit, s_rep, s_k, s_kc, s_cnt;
    logic [13:0] s_rbl, s_rbl_d;
    logic [2:0]  s_plane;
    logic [3:0]  s_plane_inc, s_eff_planes;
    logic [11:0] s_row;
    logic [12:0] s_row_inc;
    logic        s_over, s_row_done, s_img_done;
    logic [1:0]  s_err;
    logic        s_finish;
    logic        cfg_hit;
    logic [13:0] eff_bpr_new;

    // effective plane count, clamped to the build limit
    always_comb begin
        if (r_cfg_planes == 4'd0) begin
            s_eff_planes = 4'd1;
        end else if (r_cfg_planes > PLANES_MAX) begin
            s_eff_planes = PLANES_MAX;
        end else begin
            s_eff_planes = r_cfg_planes;
        end
    end

    // decode one body byte
    always_comb begin
        s_phase     = r_phase;
        s_lit       = r_lit;
        s_rep       = r_rep;
        s_k         = 8'd0;
        s_cnt       = 8'd0;
        s_over      = 1'b0;
        s_kc        = 8'd0;
        s_rbl       = r_rbl;
        s_rbl_d     = r_rbl;
        s_plane     = r_plane;
        s_plane_inc = {1'b0, r_plane} + 4'd1;
        s_row       = r_row;
        s_row_inc   = {1'b0, r_row} + 13'd1;
        s_row_done  = 1'b0;
        s_img_done  = 1'b0;
        s_err       = ERR_NONE;

        if (!r_cfg_comp) begin
            s_k = 8'd1;
        end else begin
            case (r_phase)
                PH_LITERAL: begin
                    s_k   = 8'd1;
                    s_lit = r_lit - 8'd1;
                    if (s_lit == 8'd0) begin
                        s_phase = PH_CONTROL;
                    end
                end
                PH_REPEAT: begin
                    s_k     = (r_rep > RUN_MAX) ? RUN_MAX : r_rep;
                    s_rep   = 8'd0;
                    s_phase = PH_CONTROL;
                end
                default: begin
                    s_phase = PH_CONTROL;
                    if (!i_data_byte[7]) begin
                        s_cnt = i_data_byte + 8'd1;
                    end else if (i_data_byte != CTRL_NOP) begin
                        s_cnt = 8'(9'd257 - {1'b0, i_data_byte});
                    end
                    s_over = {6'd0, s_cnt} > r_rbl;
                    if (s_cnt != 8'd0) begin
                        if (s_over) begin
                            s_err = ERR_OVERRUN;
                        end else if (!i_data_byte[7]) begin
                            s_lit   = s_cnt;
                            s_phase = PH_LITERAL;
                        end else begin
                            s_rep   = s_cnt;
                            s_phase = PH_REPEAT;
                        end
                    end
                end
            endcase
        end

        // row, plane and image bookkeeping
        if (s_k != 8'd0) begin
            s_kc    = ({6'd0, s_k} > r_rbl) ? r_rbl[7:0] : s_k;
            s_rbl_d = r_rbl - {6'd0, s_kc};
            s_rbl   = s_rbl_d;
            if (s_rbl_d == 14'd0) begin
                s_row_done = 1'b1;
                s_rbl      = f_eff_bpr(r_cfg_bpr);
                s_phase    = PH_CONTROL;
                s_lit      = 8'd0;
                s_plane    = s_plane_inc[2:0];
                if (s_plane_inc >= s_eff_planes) begin
                    s_plane = 3'd0;
                    s_row   = s_row_inc[11:0];
                    if (s_row_inc >= {1'b0, f_eff_rows(r_cfg_rows)}) begin
                        s_img_done = 1'b1;
                    end
                end
            end
        end

        if (s_err == ERR_NONE && i_end_of_body && !s_img_done) begin
            s_err = ERR_EARLY_END;
        end
    end

    assign s_finish = s_img_done || (s_err != ERR_NONE);

    // configuration decode
    assign cfg_hit = (i_cfg_addr == REG_BYTES_PER_ROW) || (i_cfg_addr == REG_PLANE_COUNT)
                  || (i_cfg_addr == REG_ROW_COUNT) || (i_cfg_addr == REG_COMPRESSION);

    always_comb begin
        n_cfg_bpr    = r_cfg_bpr;
        n_cfg_planes = r_cfg_planes;
        n_cfg_rows   = r_cfg_rows;
        n_cfg_comp   = r_cfg_comp;
        if (i_cmd.cfg_wr) begin
            case (i_cfg_addr)
                REG_BYTES_PER_ROW: n_cfg_bpr    = i_cfg_data;
                REG_PLANE_COUNT:   n_cfg_planes = i_cfg_data[3:0];
                REG_ROW_COUNT:     n_cfg_rows   = i_cfg_data[11:0];
                REG_COMPRESSION:   n_cfg_comp   = i_cfg_data[0];
                default:           n_cfg_comp   = r_cfg_comp;
            endcase
        end
    end

    assign eff_bpr_new = f_eff_bpr(n_cfg_bpr);

    // next decode state
    always_comb begin
        n_phase = r_phase;
        n_lit   = r_lit;
        n_rep   = r_rep;
        n_rbl   = r_rbl;
        n_plane = r_plane;
        n_row   = r_row;
        n_fin   = r_fin;
        if ((i_cmd.cfg_wr && cfg_hit) || (i_cmd.step && i_end_of_body
                && (r_fin || s_finish))) begin
            // restart at the top of an image
            n_phase = PH_CONTROL;
            n_lit   = 8'd0;
            n_rep   = 8'd0;
            n_rbl   = eff_bpr_new;
            n_plane = 3'd0;
            n_row   = 12'd0;
            n_fin   = 1'b0;
        end else if (i_cmd.step && !r_fin) begin
            n_phase = s_phase;
            n_lit   = s_lit;
            n_rep   = s_rep;
            n_rbl   = s_rbl;
            n_plane = s_plane;
            n_row   = s_row;
            n_fin   = s_finish;
        end
    end

    // config and decode state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bpr    <= 14'd2;
            r_cfg_planes <= 4'd1;
            r_cfg_rows   <= 12'd1;
            r_cfg_comp   <= 1'b1;
            r_phase      <= PH_CONTROL;
            r_lit        <= 8'd0;
            r_rep        <= 8'd0;
            r_rbl        <= 14'd2;
            r_plane      <= 3'd0;
            r_row        <= 12'd0;
            r_fin        <= 1'b0;
        end else begin
            r_cfg_bpr    <= n_cfg_bpr;
            r_cfg_planes <= n_cfg_planes;
            r_cfg_rows   <= n_cfg_rows;
            r_cfg_comp   <= n_cfg_comp;
            r_phase      <= n_phase;
            r_lit        <= n_lit;
            r_rep        <= n_rep;
            r_rbl        <= n_rbl;
            r_plane      <= n_plane;
            r_row        <= n_row;
            r_fin        <= n_fin;
        end
    end

    // emitter: up to two bytes per word, flags on the last word only
    assign n_em_left = (r_em_left >= 8'd2) ? (r_em_left - 8'd2) : 8'd0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_em_byte    <= i_data_byte;
            r_em_left    <= s_kc;
            r_em_plane   <= r_plane;
            r_em_row_end <= s_row_done;
            r_em_img_end <= s_finish;
            r_em_err     <= s_err;
        end else if (i_cmd.load) begin
            r_em_left    <= n_em_left;
        end
    end

    // output register, valid cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // an error word with no bytes carries an all-zero pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_pair    <= {(r_em_left != 8'd0) ? r_em_byte : 8'd0,
                              (r_em_left >= 8'd2) ? r_em_byte : 8'd0};
            r_out_count   <= (r_em_left >= 8'd2) ? 2'd2 : r_em_left[1:0];
            r_out_plane   <= r_em_plane;
            r_out_row_end <= o_status.emit_last && r_em_row_end;
            r_out_img_end <= o_status.emit_last && r_em_img_end;
            r_out_err     <= o_status.emit_last ? r_em_err : ERR_NONE;
        end
    end

    // status to controller
    assign o_status.has_result = !r_fin && ((s_kc != 8'd0) || (s_err != ERR_NONE));
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.emit_last  = r_em_left <= 8'd2;

    assign o_out_valid   = r_out_valid;
    assign o_byte_pair   = r_out_pair;
    assign o_pair_count  = r_out_count;
    assign o_plane_index = r_out_plane;
    assign o_row_end     = r_out_row_end;
    assign o_image_end   = r_out_img_end;
    assign o_error_code  = r_out_err;

endmodule

>>> sv/byterun1_bitplane_decoder_unit.sv
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder unit
// Decodes a ByteRun1 (PackBits) or raw interleaved bitplane image body into
// plane bytes, row by row and plane by plane.
// ----------------------------------------------------------------------------
// Body bytes are taken one at a time. A byte that decodes to plane bytes
// then moves to the emitter, which loads one output word (up to two bytes)
// per cycle while the output register is free; the next byte is taken only
// once its last word is loaded. Control bytes that emit nothing leave the
// decoder ready for the next byte. Output back-pressure holds the emitter
// only while the output register is still full. A run longer than what
// is left of the current plane row ends the image with error 2; a body that
// ends early ends it with error 1; bytes after a finished image are dropped
// until the byte marked tlast, which rearms the decoder. Any configuration
// write with a valid index restarts the decoder at the top of an image and
// is taken only while no byte is being emitted.
// ----------------------------------------------------------------------------
`include "byterun1_bitplane_decoder_unit_assert.svh"

module byterun1_bitplane_decoder_unit #(
    parameter int MAX_PLANES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [br1bpd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [br1bpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // body bytes in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tlast,   // end_of_body
    // decoded words out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] byte_pair, [17:16] pair_count, [20:18] plane_index,
    // [21] row_end, [23:22] zero
    output logic [23:0]                       m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,   // [1:0] error_code
    output logic                              m_axis_tlast    // image_end
);
    import br1bpd_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [15:0] byte_pair;
    logic [1:0]  pair_count;
    logic [2:0]  plane_index;
    logic        row_end;

    br1bpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_cfg_valid (i_cfg_valid),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    br1bpd_datapath #(
        .MAX_PLANES (MAX_PLANES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (s_axis_tdata),
        .i_end_of_body (s_axis_tlast),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_byte_pair   (byte_pair),
        .o_pair_count  (pair_count),
        .o_plane_index (plane_index),
        .o_row_end     (row_end),
        .o_image_end   (m_axis_tlast),
        .o_error_code  (m_axis_tuser)
    );

    // pack the output word
    assign m_axis_tdata = {2'b00, row_end, plane_index, pair_count, byte_pair};

    // a word with no bytes only reports an error and closes the image
    `BR1BPD_ASSERT_SAME(a_empty_word_is_error, i_clk, i_rst_n,
        m_axis_tvalid && (pair_count == 2'd0),
        m_axis_tlast && (m_axis_tuser != ERR_NONE))

    // an error always ends the image
    `BR1BPD_ASSERT_SAME(a_error_ends_image, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser != ERR_NONE), m_axis_tlast)

    // no new byte is taken while the emitter is loading words
    `BR1BPD_ASSERT_SAME(a_no_accept_while_emit, i_clk, i_rst_n,
        cmd.load, !s_axis_tready && !o_cfg_ready)

    // a loaded word shows up valid in the next cycle
    `BR1BPD_ASSERT_NEXT(a_load_shows_valid, i_clk, i_rst_n,
        cmd.load, m_axis_tvalid)

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// ByteRun1 bitplane decoder testbench
// Streams image body bytes into the decoder under several register settings
// and checks every decoded word against a cycle-free prediction held in a
// scoreboard. The directed opening hits the no-op control byte, the longest
// literal and repeat runs, runs that overrun a row, early end of body, bytes
// after a finished image, zero and oversized register values and writes to
// unknown register indexes. Random images with random content follow, most
// of them well formed, some cut short, some with a bad run or trailing junk.
// Both stream sides idle at random, with one calm stretch in the middle.
// ----------------------------------------------------------------------------
module tb;
    import br1bpd_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
    localparam int SETTLE_CYCLES = 70;    // settle margin, sized for the longest repeat run to drain
    localparam int BODY_TARGET   = 95;    // random body bytes to send

    // indexes the decoder has no register for
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_TOP = 8'hFF;

    // one decoded output word
    typedef struct packed {
        logic [1:0]  pad;
        logic        image_end;
        logic [1:0]  err;
        logic        row_end;
        logic [2:0]  plane;
        logic [1:0]  count;
        logic [15:0] pair;
    } t_decoded_word;

    // ------------------------------------------------------------------------
    // decoder prediction and the words still owed by the block
    // ------------------------------------------------------------------------
    class t_bitplane_scoreboard;
        // registers as written
        logic [13:0] row_width;
        logic [3:0]  planes_reg;
        logic [11:0] rows_reg;
        logic        packed_mode;
        // decoder state
        t_phase      phase;
        logic [7:0]  lit_left;
        logic [7:0]  rep_len;
        int          row_left;
        int          plane_no;
        int          row_no;
        bit          done_wait;

        t_decoded_word expected_words[$];
        int unsigned   mismatches;
        int unsigned   words_checked;
        int unsigned   bytes_seen;
        int unsigned   reg_writes;

        function new();
            row_width   = 14'd2;
            planes_reg  = 4'd1;
            rows_reg    = 12'd1;
            packed_mode = 1'b1;
            mismatches    = 0;
            words_checked = 0;
            bytes_seen    = 0;
            reg_writes    = 0;
            restart();
        endfunction

        function int eff_width();
            return (row_width == 0) ? 1 : int'(row_width);
        endfunction

        function int eff_planes();
            if (planes_reg == 0) return 1;
            if (planes_reg > 8) return 8;
            return int'(planes_reg);
        endfunction

        function int eff_rows();
            return (rows_reg == 0) ? 1 : int'(rows_reg);
        endfunction

        function void restart();
            phase     = PH_CONTROL;
            lit_left  = 8'd0;
            rep_len   = 8'd0;
            row_left  = eff_width();
            plane_no  = 0;
            row_no    = 0;
            done_wait = 1'b0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // register write; unknown indexes leave everything alone
        function void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            reg_writes++;
            case (idx)
                REG_BYTES_PER_ROW: row_width   = val[13:0];
                REG_PLANE_COUNT:   planes_reg  = val[3:0];
                REG_ROW_COUNT:     rows_reg    = val[11:0];
                REG_COMPRESSION:   packed_mode = val[0];
                default:           return;
            endcase
            restart();
        endfunction

        // accepted body byte: work out the words it produces
        function void decode_byte(logic [7:0] b, logic eob);
            logic [7:0]    run_bytes[$];
            t_decoded_word step_words[$];
            t_decoded_word w;
            logic [1:0]    err;
            logic [2:0]    plane;
            bit            row_done;
            bit            img_done;
            int            cnt;
            int            k;
            int            i;

            bytes_seen++;
            err      = ERR_NONE;
            row_done = 1'b0;
            img_done = 1'b0;
            // after a finished image only end of body matters
            if (done_wait) begin
                if (eob) restart();
                return;
            end

            if (!packed_mode) begin
                run_bytes.push_back(b);
            end else if (phase == PH_LITERAL) begin
                run_bytes.push_back(b);
                lit_left = lit_left - 8'd1;
                if (lit_left == 0) phase = PH_CONTROL;
            end else if (phase == PH_REPEAT) begin
                cnt = (rep_len > RUN_MAX) ? int'(RUN_MAX) : int'(rep_len);
                repeat (cnt) run_bytes.push_back(b);
                rep_len = 8'd0;
                phase   = PH_CONTROL;
            end else begin
                phase = PH_CONTROL;
                if (b < 8'd128) begin
                    cnt = int'(b) + 1;
                    if (cnt > row_left) err = ERR_OVERRUN;
                    else begin
                        lit_left = 8'(cnt);
                        phase    = PH_LITERAL;
                    end
                end else if (b != CTRL_NOP) begin
                    cnt = 257 - int'(b);
                    if (cnt > row_left) err = ERR_OVERRUN;
                    else begin
                        rep_len = 8'(cnt);
                        phase   = PH_REPEAT;
                    end
                end
            end

            // row, plane and image bookkeeping
            plane = 3'(plane_no);
            k = run_bytes.size();
            if (k > 0) begin
                if (k > row_left) k = row_left;
                row_left -= k;
                if (row_left == 0) begin
                    row_done = 1'b1;
                    row_left = eff_width();
                    phase    = PH_CONTROL;
                    lit_left = 8'd0;
                    plane_no++;
                    if (plane_no >= eff_planes()) begin
                        plane_no = 0;
                        row_no++;
                        if (row_no >= eff_rows()) img_done = 1'b1;
                    end
                end
                for (i = 0; i < k; i += 2) begin
                    w = '0;
                    w.pair  = {run_bytes[i], (i + 1 < k) ? run_bytes[i + 1] : 8'h00};
                    w.count = (i + 1 < k) ? 2'd2 : 2'd1;
                    w.plane = plane;
                    step_words.push_back(w);
                end
            end

            if (err == ERR_NONE && eob && !img_done) err = ERR_EARLY_END;
            // an error with nothing decoded still reports once
            if (err != ERR_NONE && step_words.size() == 0) begin
                w = '0;
                w.plane = plane;
                step_words.push_back(w);
            end
            if (step_words.size() > 0) begin
                w = step_words.pop_back();
                w.row_end   = row_done;
                w.image_end = img_done || (err != ERR_NONE);
                w.err       = err;
                step_words.push_back(w);
            end
            expected_words = {expected_words, step_words};

            if (img_done || err != ERR_NONE) begin
                if (eob) restart();
                else done_wait = 1'b1;
            end
        endfunction

        function string show(t_decoded_word w);
            return $sformatf("pair=%h n=%0d plane=%0d row_end=%b img_end=%b err=%0d pad=%0d",
                             w.pair, w.count, w.plane, w.row_end, w.image_end, w.err, w.pad);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH: %s", msg);
        endfunction

        // accepted output word against the oldest expectation
        function void check_word(t_decoded_word got);
            t_decoded_word want;
            words_checked++;
            if (expected_words.size() == 0) begin
                report($sformatf("word %0d not expected: %s", words_checked, show(got)));
                return;
            end
            want = expected_words.pop_front();
            if (got.pair != want.pair || got.count != want.count ||
                got.plane != want.plane || got.row_end != want.row_end ||
                got.image_end != want.image_end || got.err != want.err ||
                got.pad != want.pad)
                report($sformatf("word %0d expected %s, got %s",
                                 words_checked, show(want), show(got)));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] data_byte
    logic                  s_axis_tlast;   // end_of_body
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [15:0] byte_pair, [17:16] pair_count, [20:18] plane_index,
    // [21] row_end, [23:22] zero
    logic [23:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;   // [1:0] error_code
    logic                  m_axis_tlast;   // image_end

    t_bitplane_scoreboard sb;
    bit                 calm = 1'b0;        // no idling on either side
    int unsigned        quiet_cycles = 0;
    int unsigned        body_items = 0;
    logic [7:0]         body_bytes[$];
    logic               body_last[$];

    byterun1_bitplane_decoder_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // output back-pressure
    always @(negedge i_clk) begin
        m_axis_tready = calm || ($urandom_range(0, 99) >= 31);
    end

    // handshake monitor: words in, register writes, words out
    always @(posedge i_clk) begin : monitor
        t_decoded_word got;
        bit            moved;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                sb.decode_byte(s_axis_tdata, s_axis_tlast);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.apply_reg(i_cfg_addr, i_cfg_data);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.pad       = m_axis_tdata[23:22];
                got.row_end   = m_axis_tdata[21];
                got.plane     = m_axis_tdata[20:18];
                got.count     = m_axis_tdata[17:16];
                got.pair      = m_axis_tdata[15:0];
                got.image_end = m_axis_tlast;
                got.err       = m_axis_tuser;
                sb.check_word(got);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    // watchdog
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("no handshake for %0d cycles, %0d words still owed",
                 STALL_LIMIT, sb.pending());
        $display("TB_ERROR");
        $finish;
    end

    // control byte for a literal or a repeat run of n bytes
    function automatic logic [7:0] lit_ctrl(input int n);
        return 8'(n - 1);
    endfunction

    function automatic logic [7:0] rep_ctrl(input int n);
        return 8'(257 - n);
    endfunction

    function automatic void push_byte(input logic [7:0] v);
        body_bytes.push_back(v);
        body_last.push_back(1'b0);
    endfunction

    // one image body: mostly well formed, else cut short, a bad run or junk
    function automatic void build_body(input int width, input int planes, input int rows,
                                       input bit packed_mode);
        int mode;
        int bad_row;
        int rw;
        int left;
        int n;
        int cut;
        body_bytes.delete();
        body_last.delete();
        mode    = $urandom_range(0, 9);   // 0 cut short, 1 bad run, 2 junk tail
        bad_row = $urandom_range(0, planes * rows - 1);
        for (rw = 0; rw < planes * rows; rw++) begin
            left = width;
            while (left > 0) begin
                if (!packed_mode) begin
                    push_byte(8'($urandom));
                    left--;
                end else if (mode == 1 && rw == bad_row) begin
                    // run one byte longer than what is left of the row, then junk up to end of body
                    n = left + 1;
                    push_byte($urandom_range(0, 1) ? rep_ctrl(n) : lit_ctrl(n));
                    push_byte(8'($urandom));
                    push_byte(8'($urandom));
                    body_last[body_last.size() - 1] = 1'b1;
                    return;
                end else begin
                    if ($urandom_range(0, 7) == 0) push_byte(CTRL_NOP);
                    n = $urandom_range(1, (left < 128) ? left : 128);
                    if (n > 1 && $urandom_range(0, 1)) begin
                        push_byte(rep_ctrl(n));
                        push_byte(8'($urandom));
                    end else begin
                        push_byte(lit_ctrl(n));
                        repeat (n) push_byte(8'($urandom));
                    end
                    left -= n;
                end
            end
        end
        if (mode == 0 && body_bytes.size() > 1) begin
            cut = $urandom_range(1, body_bytes.size() - 1);
            body_bytes = body_bytes[0:cut-1];
            body_last  = body_last[0:cut-1];
        end else if (mode == 2) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        end
        body_last[body_last.size() - 1] = 1'b1;
    endfunction

    // one body byte; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] d, input logic l);
        while (!calm && $urandom_range(0, 99) < 31) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        s_axis_tlast  = l;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] p,
                                input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] c);
        write_reg(REG_BYTES_PER_ROW, w);
        write_reg(REG_PLANE_COUNT, p);
        write_reg(REG_ROW_COUNT, r);
        write_reg(REG_COMPRESSION, c);
    endtask

    // wait for every owed word, then for any no-result byte still in flight
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          i;
        int          w;
        int          p;
        int          r;
        int          ew;
        int          ep;
        int          er;
        bit          c;
        int unsigned phases;

        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        phases        = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: 2-byte rows, one plane, one row, compressed
        send_byte(CTRL_NOP, 1'b0);
        send_byte(lit_ctrl(2), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);           // image done, decoder waits
        send_byte(8'h55, 1'b0);           // ignored
        send_byte(8'hAA, 1'b1);           // ignored, rearms
        send_byte(rep_ctrl(2), 1'b0);
        send_byte(8'hA5, 1'b1);           // completes and rearms at once
        send_byte(lit_ctrl(3), 1'b0);     // literal longer than the row
        send_byte(8'h3C, 1'b1);           // ignored, rearms
        send_byte(rep_ctrl(3), 1'b1);     // repeat longer than the row, rearms
        send_byte(lit_ctrl(1), 1'b1);     // body ends with nothing decoded
        wait_idle();

        // longest repeat fills a 128-byte row in one go
        apply_config(14'd128, 14'd1, 14'd1, 14'd1);
        send_byte(rep_ctrl(128), 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(lit_ctrl(128), 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b1);           // body ends inside the literal
        wait_idle();

        // zero registers act as one; raw mode
        apply_config(14'd0, 14'd0, 14'd0, 14'd0);
        send_byte(8'h99, 1'b1);
        send_byte(8'h42, 1'b0);
        send_byte(8'h13, 1'b1);
        wait_idle();

        // all-ones writes; unknown indexes must not restart a pending literal
        apply_config(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        send_byte(lit_ctrl(128), 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        wait_idle();
        write_reg(REG_UNUSED_TOP, 14'h0000);
        write_reg(REG_UNUSED_LOW, 14'h2AAA);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);
        wait_idle();

        // random settings, a few images each
        while (body_items < BODY_TARGET) begin
            w = $urandom_range(2, 8);
            p = $urandom_range(1, 3);
            r = $urandom_range(1, 3);
            case ($urandom_range(0, 7))
                0: w = 0;
                1: begin
                    p = $urandom_range(8, 15);
                    w = $urandom_range(1, 3);
                    r = 1;
                end
                2: p = 0;
                3: r = 0;
                4: begin
                    w = $urandom_range(9, 40);
                    p = 1;
                    r = 1;
                end
                default: ;
            endcase
            c  = ($urandom_range(0, 3) != 0);
            ew = (w == 0) ? 1 : w;
            ep = (p == 0) ? 1 : ((p > 8) ? 8 : p);
            er = (r == 0) ? 1 : r;
            // unused upper data bits carry noise
            apply_config(14'(w), {10'($urandom), 4'(p)}, {2'($urandom), 12'(r)},
                         {13'($urandom), c});
            phases++;
            repeat ($urandom_range(1, 3)) begin
                // stop starting new bodies once the byte budget is spent
                if (body_items < BODY_TARGET) begin
                    build_body(ew, ep, er, c);
                    for (i = 0; i < body_bytes.size(); i++) begin
                        calm = (body_items >= 45 && body_items < 85);
                        send_byte(body_bytes[i], body_last[i]);
                        body_items++;
                    end
                end
            end
            calm = 1'b0;
            wait_idle();
        end

        $display("covered %0d body bytes and %0d register writes over %0d random settings",
                 sb.bytes_seen, sb.reg_writes, phases);
        $display("checked %0d decoded words, %0d mismatches", sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/br1bpd_pkg.sv
sv/br1bpd_ctrl.sv
sv/br1bpd_datapath.sv
sv/byterun1_bitplane_decoder_unit.sv
tb/tb.sv
